// ===== design/khp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khp_pkg
// Shared constants, status codes and controller/datapath interface types for
// the k-mer hash table probe unit.
// ----------------------------------------------------------------------------
package khp_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_MAX_K       = 32;
    localparam int DEF_NODE_DEPTH  = 4096;

    localparam int SYM_W     = 7;
    localparam int CONTIG_W  = 16;
    localparam int POS_W     = 24;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 10;
    localparam int NODE_W    = 12;
    localparam int TSIZE_W   = 11;
    localparam int KLEN_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int HASH_W    = 32;
    localparam int DCNT_W    = 5;
    localparam int HASH_SH_HI = 16;
    localparam int HASH_SH_LO = 6;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    localparam logic [TSIZE_W-1:0] TSIZE_RST = 11'd1024;
    localparam logic [KLEN_W-1:0]  KLEN_RST  = 6'd21;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH = 1'b1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_NEW   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TFULL = 3'd4;
    localparam logic [STATUS_W-1:0] ST_PFULL = 3'd5;

    // probe outcome
    localparam logic [1:0] RES_MATCH = 2'd0;
    localparam logic [1:0] RES_EMPTY = 2'd1;
    localparam logic [1:0] RES_FULL  = 2'd2;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic mod_step;
        logic probe_init;
        logic head_rd;
        logic j_clr;
        logic key_rd;
        logic j_inc;
        logic probe_next;
        logic set_match;
        logic set_empty;
        logic set_full;
        logic commit;
        logic copy_step;
    } t_dp_cmd;

    typedef struct packed {
        logic last_char;
        logic clr_last;
        logic mod_last;
        logic slot_used;
        logic key_eq;
        logic j_last;
        logic probe_last;
        logic out_free;
        logic need_copy;
        logic copy_last;
    } t_dp_sts;

endpackage

// ===== design/kmer_hash_table_probe_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_hash_table_probe_unit
// K-mer hash table with SDBM hash and linear probing, one character per item.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one k-mer character per item; tuser is the operation
//   (insert/search), read on the last character only. Master stream: one
//   result item per completed k-mer. Configuration: plain write port, index 0
//   table size, index 1 k-mer length; write only while idle.
// Sequence:
//   A character that does not complete a k-mer is stored and hashed. A completing
//   character runs the bit-serial modulo and the probe setup, then per probed
//   slot a slot read plus a key read and compare per compared character, a
//   commit, and a copy of all MAX_K key characters when a new key is stored.
//   The modulo and the one-character-per-read key memory dominate the run time.
// Reset:
//   The slot memory is swept clear, all TABLE_DEPTH slots, after reset;
//   s_tready stays low during the sweep.
// Stall:
//   A result waits in the output register; the unit keeps taking characters
//   and holds only when a new result is ready while the register is full.
// ----------------------------------------------------------------------------
module kmer_hash_table_probe_unit
    import khp_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_K       = DEF_MAX_K,
    parameter int NODE_DEPTH  = DEF_NODE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // symbol, contig_index, position, zero pad
    input  logic                 i_s_tuser,  // operation
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // slot_index, node_index, zero pad
    output logic [STATUS_W-1:0]  o_m_tuser,  // status
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TSIZE_W-1:0]   i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    khp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    khp_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_K       (MAX_K),
        .NODE_DEPTH  (NODE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ===== design/khp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khp_ctrl
// Sequencer: clearing pass, hash modulo, linear probe with key compare,
// commit and key copy.
// ----------------------------------------------------------------------------
module khp_ctrl
    import khp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_PINIT = 4'd3;
    localparam logic [3:0] S_PRD   = 4'd4;
    localparam logic [3:0] S_PCHK  = 4'd5;
    localparam logic [3:0] S_KRD   = 4'd6;
    localparam logic [3:0] S_KCMP  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_COPY  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.last_char) begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_PINIT;
                end
            end
            S_PINIT: begin
                o_cmd.probe_init = 1'b1;
                n_state = S_PRD;
            end
            S_PRD: begin
                o_cmd.head_rd = 1'b1;
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (!i_sts.slot_used) begin
                    o_cmd.set_empty = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.j_clr = 1'b1;
                    n_state = S_KRD;
                end
            end
            S_KRD: begin
                o_cmd.key_rd = 1'b1;
                n_state = S_KCMP;
            end
            S_KCMP: begin
                if (!i_sts.key_eq) begin
                    // mismatch: step to the next slot or give up after a full lap
                    if (i_sts.probe_last) begin
                        o_cmd.set_full = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        o_cmd.probe_next = 1'b1;
                        n_state = S_PRD;
                    end
                end else if (i_sts.j_last) begin
                    o_cmd.set_match = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state = S_KRD;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    if (i_sts.need_copy) begin
                        o_cmd.j_clr = 1'b1;
                        n_state = S_COPY;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/khp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khp_dp
// Datapath: k-mer buffer, SDBM hash, serial modulo, slot/key/node memories,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module khp_dp
    import khp_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_K       = DEF_MAX_K,
    parameter int NODE_DEPTH  = DEF_NODE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [STATUS_W-1:0]  o_m_tuser,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TSIZE_W-1:0]   i_cfg_data
);

    localparam int SW        = $clog2(TABLE_DEPTH);
    localparam int NW        = $clog2(TABLE_DEPTH + 1);
    localparam int KW        = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KCW       = $clog2(MAX_K + 1);
    localparam int NDW       = $clog2(NODE_DEPTH);
    localparam int NCW       = $clog2(NODE_DEPTH + 1);
    localparam int KEY_DEPTH = TABLE_DEPTH * (2 ** KW);
    localparam int NODE_BITS = CONTIG_W + POS_W + NDW;

    // configuration
    logic [TSIZE_W-1:0] r_tsize;
    logic [KLEN_W-1:0]  r_klen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsize <= TSIZE_RST;
            r_klen  <= KLEN_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_TABLE_SIZE) begin
                r_tsize <= i_cfg_data;
            end else if (i_cfg_index == CFG_KMER_LENGTH) begin
                r_klen <= i_cfg_data[KLEN_W-1:0];
            end
        end
    end

    logic [NW-1:0]  w_n;
    logic [KCW-1:0] w_k;

    always_comb begin
        if (r_tsize == '0) begin
            w_n = NW'(1);
        end else if (32'(r_tsize) > 32'(TABLE_DEPTH)) begin
            w_n = NW'(TABLE_DEPTH);
        end else begin
            w_n = NW'(r_tsize);
        end
        if (r_klen == '0) begin
            w_k = KCW'(1);
        end else if (32'(r_klen) > 32'(MAX_K)) begin
            w_k = KCW'(MAX_K);
        end else begin
            w_k = KCW'(r_klen);
        end
    end

    // input item fields
    logic [SYM_W-1:0]    w_sym;
    logic [CONTIG_W-1:0] w_contig;
    logic [POS_W-1:0]    w_pos;

    assign w_sym    = i_s_tdata[SYM_W-1:0];
    assign w_contig = i_s_tdata[SYM_W +: CONTIG_W];
    assign w_pos    = i_s_tdata[SYM_W+CONTIG_W +: POS_W];

    // k-mer buffer, hash and divider
    logic [SYM_W-1:0]    r_buf [MAX_K];
    logic [KW-1:0]       r_cnt;
    logic [HASH_W-1:0]   r_hash;
    logic [HASH_W-1:0]   n_hash;
    logic [HASH_W-1:0]   r_div;
    logic [NW-1:0]       r_rem;
    logic [DCNT_W-1:0]   r_dcnt;
    logic                r_op;
    logic [CONTIG_W-1:0] r_contig;
    logic [POS_W-1:0]    r_pos;
    logic                w_last;
    logic [NW:0]         w_trial;
    logic [NW:0]         w_sub;

    // h * 65599 + c
    assign n_hash = (r_hash << HASH_SH_HI) + (r_hash << HASH_SH_LO) - r_hash
                  + HASH_W'(w_sym);
    assign w_last = ((KCW+1)'(r_cnt) + (KCW+1)'(1)) >= (KCW+1)'(w_k);
    assign w_trial = {r_rem, r_div[HASH_W-1]};
    assign w_sub   = w_trial - (NW+1)'(w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_hash <= '0;
        end else if (i_cmd.accept) begin
            if (w_last) begin
                r_cnt  <= '0;
                r_hash <= '0;
            end else begin
                r_cnt  <= r_cnt + KW'(1);
                r_hash <= n_hash;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_buf[r_cnt] <= w_sym;
            if (w_last) begin
                r_div    <= n_hash;
                r_rem    <= '0;
                r_dcnt   <= '0;
                r_op     <= i_s_tuser;
                r_contig <= w_contig;
                r_pos    <= w_pos;
            end
        end else if (i_cmd.mod_step) begin
            // restoring division, one quotient bit a cycle
            r_div  <= r_div << 1;
            r_dcnt <= r_dcnt + DCNT_W'(1);
            if (!w_sub[NW]) begin
                r_rem <= w_sub[NW-1:0];
            end else begin
                r_rem <= w_trial[NW-1:0];
            end
        end
    end

    // probe position
    logic [SW-1:0] r_idx;
    logic [NW-1:0] r_pcnt;
    logic [KW-1:0] r_j;
    logic [1:0]    r_res;
    logic [NW-1:0] w_idx_inc;

    assign w_idx_inc = NW'(r_idx) + NW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_idx  <= SW'(r_rem);
            r_pcnt <= '0;
        end else if (i_cmd.probe_next) begin
            r_pcnt <= r_pcnt + NW'(1);
            if (w_idx_inc >= w_n) begin
                r_idx <= '0;
            end else begin
                r_idx <= SW'(w_idx_inc);
            end
        end
        if (i_cmd.j_clr) begin
            r_j <= '0;
        end else if (i_cmd.j_inc || i_cmd.copy_step) begin
            r_j <= r_j + KW'(1);
        end
        if (i_cmd.set_match) begin
            r_res <= RES_MATCH;
        end else if (i_cmd.set_empty) begin
            r_res <= RES_EMPTY;
        end else if (i_cmd.set_full) begin
            r_res <= RES_FULL;
        end
    end

    // slot memory: used flag and list head; cleared by a sweep after reset
    logic [NDW:0]   r_head_mem [TABLE_DEPTH];
    logic [NDW:0]   r_head_q;
    logic [SW-1:0]  r_clr;
    logic [NCW-1:0] r_nodes;
    logic           w_pool_full;
    logic           w_ins_ok;
    logic [NDW-1:0] w_node;

    assign w_pool_full = (r_nodes == NCW'(NODE_DEPTH));
    assign w_ins_ok    = (r_op == OP_INSERT) && (r_res != RES_FULL) && !w_pool_full;
    assign w_node      = NDW'(r_nodes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_nodes <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + SW'(1);
            end
            if (i_cmd.commit && w_ins_ok) begin
                r_nodes <= r_nodes + NCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_head_mem[r_clr] <= '0;
        end else if (i_cmd.commit && w_ins_ok) begin
            r_head_mem[r_idx] <= {1'b1, w_node};
        end
        if (i_cmd.head_rd) begin
            r_head_q <= r_head_mem[r_idx];
        end
    end

    // key memory, one character per word
    logic [SYM_W-1:0] r_key_mem [KEY_DEPTH];
    logic [SYM_W-1:0] r_key_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_step) begin
            r_key_mem[{r_idx, r_j}] <= r_buf[r_j];
        end
        if (i_cmd.key_rd) begin
            r_key_q <= r_key_mem[{r_idx, r_j}];
        end
    end

    // occurrence nodes: {next, position, contig}
    logic [NODE_BITS-1:0] r_node_mem [NODE_DEPTH];
    logic [NDW-1:0]       w_next;

    assign w_next = (r_res == RES_MATCH) ? r_head_q[NDW-1:0] : w_node;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_ins_ok) begin
            r_node_mem[w_node] <= {w_next, r_pos, r_contig};
        end
    end

    // result
    logic [STATUS_W-1:0] w_status;
    logic [SW-1:0]       w_slot;
    logic [NDW-1:0]      w_res_node;

    always_comb begin
        w_slot     = '0;
        w_res_node = '0;
        if (r_op == OP_SEARCH) begin
            if (r_res == RES_MATCH) begin
                w_status = ST_HIT;
                w_slot   = r_idx;
            end else begin
                w_status = ST_MISS;
            end
        end else if (r_res == RES_FULL) begin
            w_status = ST_TFULL;
        end else if (w_pool_full) begin
            w_status = ST_PFULL;
        end else begin
            w_status   = (r_res == RES_MATCH) ? ST_ADDED : ST_NEW;
            w_slot     = r_idx;
            w_res_node = w_node;
        end
    end

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [NODE_W-1:0]   r_out_node;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= w_status;
            r_out_slot   <= SLOT_W'(w_slot);
            r_out_node   <= NODE_W'(w_res_node);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{(M_TDATA_W-SLOT_W-NODE_W){1'b0}}, r_out_node, r_out_slot};

    assign o_sts.last_char  = w_last;
    assign o_sts.clr_last   = (r_clr == SW'(TABLE_DEPTH - 1));
    assign o_sts.mod_last   = (r_dcnt == {DCNT_W{1'b1}});
    assign o_sts.slot_used  = r_head_q[NDW];
    assign o_sts.key_eq     = (r_key_q == r_buf[r_j]);
    assign o_sts.j_last     = ((KCW+1)'(r_j) + (KCW+1)'(1)) == (KCW+1)'(w_k);
    assign o_sts.probe_last = (r_pcnt + NW'(1)) == w_n;
    assign o_sts.out_free   = !r_out_valid || i_m_tready;
    assign o_sts.need_copy  = w_ins_ok && (r_res == RES_EMPTY);
    assign o_sts.copy_last  = (r_j == KW'(MAX_K - 1));

endmodule

// ===== design/khp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khp_checker
// Port-level checks for the k-mer hash table probe unit.
// ----------------------------------------------------------------------------
module khp_checker
    import khp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [STATUS_W-1:0]  o_m_tuser
);

    // the slot sweep follows every reset
    a_sweep_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input ready during slot sweep");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser <= ST_PFULL)
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_MISS || o_m_tuser == ST_TFULL
            || o_m_tuser == ST_PFULL) |-> o_m_tdata == '0)
        else $error("nonzero index on miss or error");

    a_hit_no_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_HIT |-> o_m_tdata[SLOT_W +: NODE_W] == '0)
        else $error("node index on search hit");

endmodule

bind kmer_hash_table_probe_unit khp_checker u_khp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
